FILE: rtl/gcd_pkg.sv
`timescale 1ns / 1ps

package gcd_pkg;

    localparam int MAX_DIM = 1024;

    // configuration register indexes
    localparam logic [2:0] REG_SIZE_I = 3'd0;
    localparam logic [2:0] REG_SIZE_J = 3'd1;
    localparam logic [2:0] REG_SIZE_K = 3'd2;
    localparam logic [2:0] REG_SHAPE  = 3'd3;

    // cell_shape codes
    localparam logic [1:0] SHAPE_TET   = 2'd0;
    localparam logic [1:0] SHAPE_HEX   = 2'd1;
    localparam logic [1:0] SHAPE_PYR   = 2'd2;
    localparam logic [1:0] SHAPE_PRISM = 2'd3;

    // element_kind codes
    localparam logic [1:0] KIND_TET   = 2'd0;
    localparam logic [1:0] KIND_PYR   = 2'd1;
    localparam logic [1:0] KIND_PRISM = 2'd2;
    localparam logic [1:0] KIND_HEX   = 2'd3;

    typedef struct packed {
        logic [9:0] corner_a;
        logic [9:0] corner_b;
        logic [9:0] corner_c;
        logic       start_grid;
    } in_t;

    typedef struct packed {
        logic [32:0] element_number;
        logic [34:0] conn_offset;
        logic [1:0]  element_kind;
        logic [29:0] vertex_0;
        logic [29:0] vertex_1;
        logic [29:0] vertex_2;
        logic [29:0] vertex_3;
        logic [29:0] vertex_4;
        logic [29:0] vertex_5;
        logic [29:0] vertex_6;
        logic [29:0] vertex_7;
        logic        last_of_cell;
    } out_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [10:0] size_i;
        logic [10:0] size_j;
        logic [10:0] size_k;
        logic [1:0]  shape;
        logic [20:0] plane;   // J*K, points per first-axis slab
    } cfg_t;

    // cell after the multiply stage
    typedef struct packed {
        logic [29:0] row0;    // a*J*K
        logic [20:0] col0;    // b*K
        logic [9:0]  corner_c;
        logic        start_grid;
        logic        in_grid;
    } cell_t;

    // corner of each vertex slot, by shape, element and slot
    localparam logic [0:3][0:5][0:7][2:0] CORNER_TBL = '{
        '{ '{3'd0, 3'd1, 3'd2, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd2, 3'd3, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd1, 3'd5, 3'd6, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd1, 3'd6, 3'd2, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd1, 3'd0, 3'd4, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd1, 3'd4, 3'd5, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0} },
        '{ '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0} },
        '{ '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd0, 3'd0, 3'd0},
           '{3'd1, 3'd5, 3'd6, 3'd2, 3'd7, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd1, 3'd5, 3'd4, 3'd7, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0} },
        '{ '{3'd0, 3'd3, 3'd4, 3'd1, 3'd2, 3'd5, 3'd0, 3'd0},
           '{3'd7, 3'd4, 3'd3, 3'd6, 3'd5, 3'd2, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
           '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0} }
    };

    function automatic logic [2:0] shape_elems(input logic [1:0] shape);
        logic [2:0] n;
        unique case (shape)
            SHAPE_TET:   n = 3'd6;
            SHAPE_HEX:   n = 3'd1;
            SHAPE_PYR:   n = 3'd3;
            SHAPE_PRISM: n = 3'd2;
            default:     n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] shape_verts(input logic [1:0] shape);
        logic [3:0] n;
        unique case (shape)
            SHAPE_TET:   n = 4'd4;
            SHAPE_HEX:   n = 4'd8;
            SHAPE_PYR:   n = 4'd5;
            SHAPE_PRISM: n = 4'd6;
            default:     n = 4'd8;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] shape_kind(input logic [1:0] shape);
        logic [1:0] k;
        unique case (shape)
            SHAPE_TET:   k = KIND_TET;
            SHAPE_HEX:   k = KIND_HEX;
            SHAPE_PYR:   k = KIND_PYR;
            SHAPE_PRISM: k = KIND_PRISM;
            default:     k = KIND_HEX;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/gcd_cfg_regs.sv
`timescale 1ns / 1ps

module gcd_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    output gcd_pkg::cfg_t      cfg
);

    logic [10:0] size_i_reg, size_j_reg, size_k_reg;
    logic [1:0]  shape_reg;
    logic [20:0] plane_reg;
    logic [10:0] clamped;
    logic [21:0] plane_prod;

    // sizes above the grid limit saturate
    assign clamped = (cfg_data > 11'(gcd_pkg::MAX_DIM)) ? 11'(gcd_pkg::MAX_DIM) : cfg_data;
    assign plane_prod = 22'(size_j_reg) * 22'(size_k_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_i_reg <= '0;
            size_j_reg <= '0;
            size_k_reg <= '0;
            shape_reg  <= gcd_pkg::SHAPE_HEX;
            plane_reg  <= '0;
        end else begin
            plane_reg <= plane_prod[20:0];
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    gcd_pkg::REG_SIZE_I: size_i_reg <= clamped;
                    gcd_pkg::REG_SIZE_J: size_j_reg <= clamped;
                    gcd_pkg::REG_SIZE_K: size_k_reg <= clamped;
                    gcd_pkg::REG_SHAPE:  shape_reg  <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    assign cfg.size_i = size_i_reg;
    assign cfg.size_j = size_j_reg;
    assign cfg.size_k = size_k_reg;
    assign cfg.shape  = shape_reg;
    assign cfg.plane  = plane_reg;

endmodule

FILE: rtl/gcd_corner_calc.sv
`timescale 1ns / 1ps

module gcd_corner_calc (
    input  logic               aclk,
    input  logic               aresetn,
    input  gcd_pkg::cfg_t      cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  gcd_pkg::in_t       s_data,
    output logic               cell_valid,
    input  logic               cell_ready,
    output gcd_pkg::cell_t     cell_data
);

    logic           in_valid_reg;
    gcd_pkg::in_t   in_reg;
    logic           cell_valid_reg;
    gcd_pkg::cell_t cell_reg;
    gcd_pkg::cell_t cell_next;
    logic           adv;
    logic [30:0]    row_prod;

    assign adv     = in_valid_reg && (!cell_valid_reg || cell_ready);
    assign s_ready = !in_valid_reg || adv;

    always_comb begin
        row_prod = 31'(in_reg.corner_a) * 31'(cfg.plane);
        cell_next.row0       = row_prod[29:0];
        cell_next.col0       = 21'(in_reg.corner_b) * 21'(cfg.size_k);
        cell_next.corner_c   = in_reg.corner_c;
        cell_next.start_grid = in_reg.start_grid;
        cell_next.in_grid    = ((11'(in_reg.corner_a) + 11'd1) < cfg.size_i)
                            && ((11'(in_reg.corner_b) + 11'd1) < cfg.size_j)
                            && ((11'(in_reg.corner_c) + 11'd1) < cfg.size_k);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            cell_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                in_valid_reg <= 1'b1;
            else if (adv)
                in_valid_reg <= 1'b0;
            if (adv)
                cell_valid_reg <= 1'b1;
            else if (cell_ready)
                cell_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_reg <= s_data;
        if (adv)
            cell_reg <= cell_next;
    end

    assign cell_valid = cell_valid_reg;
    assign cell_data  = cell_reg;

endmodule

FILE: rtl/gcd_emitter.sv
`timescale 1ns / 1ps

module gcd_emitter (
    input  logic               aclk,
    input  logic               aresetn,
    input  gcd_pkg::cfg_t      cfg,
    input  logic               cell_valid,
    output logic               cell_ready,
    input  gcd_pkg::cell_t     cell_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gcd_pkg::out_t      m_data
);

    logic               busy_reg;
    logic [2:0]         elem_reg;
    logic [1:0]         shape_reg;
    logic [7:0][29:0]   pts_reg;
    logic [32:0]        counter_reg, counter_next;
    logic               m_valid_reg;
    gcd_pkg::out_t      m_data_reg;

    logic               out_free, emit, last, load;
    logic [3:0]         verts;
    logic [34:0]        conn;
    logic [7:0][29:0]   pts_next;
    logic [7:0][29:0]   vtx;
    logic [29:0]        row1;
    logic [20:0]        col1;
    logic [29:0]        c_ext;
    gcd_pkg::out_t      out_next;

    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = busy_reg && out_free;
    assign last       = (elem_reg == gcd_pkg::shape_elems(shape_reg) - 3'd1);
    assign cell_ready = !busy_reg || (emit && last);
    assign load       = cell_valid && cell_ready;
    assign verts      = gcd_pkg::shape_verts(shape_reg);

    // corner points of the incoming cell
    always_comb begin
        row1  = cell_data.row0 + 30'(cfg.plane);
        col1  = cell_data.col0 + 21'(cfg.size_k);
        c_ext = 30'(cell_data.corner_c);
        pts_next[0] = cell_data.row0 + 30'(cell_data.col0) + c_ext;
        pts_next[1] = row1           + 30'(cell_data.col0) + c_ext;
        pts_next[2] = row1           + 30'(col1)           + c_ext;
        pts_next[3] = cell_data.row0 + 30'(col1)           + c_ext;
        pts_next[4] = cell_data.row0 + 30'(cell_data.col0) + c_ext + 30'd1;
        pts_next[5] = row1           + 30'(cell_data.col0) + c_ext + 30'd1;
        pts_next[6] = row1           + 30'(col1)           + c_ext + 30'd1;
        pts_next[7] = cell_data.row0 + 30'(col1)           + c_ext + 30'd1;
    end

    // counter times vertex count, as shifts and one add
    always_comb begin
        unique case (shape_reg)
            gcd_pkg::SHAPE_TET:   conn = {counter_reg, 2'b00};
            gcd_pkg::SHAPE_HEX:   conn = {counter_reg[31:0], 3'b000};
            gcd_pkg::SHAPE_PYR:   conn = {counter_reg, 2'b00} + {2'b00, counter_reg};
            gcd_pkg::SHAPE_PRISM: conn = {counter_reg, 2'b00} + {1'b0, counter_reg, 1'b0};
            default:              conn = {counter_reg[31:0], 3'b000};
        endcase
    end

    always_comb begin
        for (int s = 0; s < 8; s++) begin
            if (4'(s) < verts)
                vtx[s] = pts_reg[gcd_pkg::CORNER_TBL[shape_reg][elem_reg][s]];
            else
                vtx[s] = '0;
        end
        out_next.element_number = counter_reg;
        out_next.conn_offset    = conn;
        out_next.element_kind   = gcd_pkg::shape_kind(shape_reg);
        out_next.vertex_0       = vtx[0];
        out_next.vertex_1       = vtx[1];
        out_next.vertex_2       = vtx[2];
        out_next.vertex_3       = vtx[3];
        out_next.vertex_4       = vtx[4];
        out_next.vertex_5       = vtx[5];
        out_next.vertex_6       = vtx[6];
        out_next.vertex_7       = vtx[7];
        out_next.last_of_cell   = last;
    end

    // start flag of the next cell wins over the last increment
    always_comb begin
        counter_next = counter_reg;
        if (emit)
            counter_next = counter_reg + 33'd1;
        if (load && cell_data.start_grid)
            counter_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            elem_reg    <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            counter_reg <= counter_next;
            if (load) begin
                elem_reg <= '0;
                busy_reg <= cell_data.in_grid;
            end else if (emit) begin
                elem_reg <= elem_reg + 3'd1;
                if (last)
                    busy_reg <= 1'b0;
            end
            if (out_free)
                m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pts_reg   <= pts_next;
            shape_reg <= cfg.shape;
        end
        if (emit)
            m_data_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/grid_cell_decomposer.sv
`timescale 1ns / 1ps
// Each cell passes the input, cell and output registers before its elements reach m_data.
// Throughput: one cell per cycle into the pipe while not stalled; the emitter sends one
//   element per cycle while m_ready allows: 6 (tetrahedra), 3 (pyramids), 2 (prisms) or
//   1 (hexahedron) elements per cell; a cell outside the grid yields no elements.
// Reset: synchronous, active low; sizes clear to 0, shape to hexahedra, counter to 0.

module grid_cell_decomposer (
    input  logic           aclk,
    input  logic           aresetn,
    // configuration writes
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [10:0]    cfg_data,
    // cell input
    input  logic           s_valid,
    output logic           s_ready,
    input  gcd_pkg::in_t   s_data,
    // element output
    output logic           m_valid,
    input  logic           m_ready,
    output gcd_pkg::out_t  m_data
);

    gcd_pkg::cfg_t  cfg;
    gcd_pkg::cell_t cell_data;
    logic           cell_valid;
    logic           cell_ready;

    // config registers plus the registered J*K plane size
    gcd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register, then a*JK and b*K products with the grid bounds check
    gcd_corner_calc u_calc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data)
    );

    // corner points, element counter, one element per transfer into the output register
    gcd_emitter u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
